FILE: rtl/tte_pkg.sv
package tte_pkg;

	// request action codes
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_CANCEL = 2'd1;
	localparam logic [1:0] ACT_WALK   = 2'd2;

	// result kind codes
	localparam logic [1:0] KIND_ADDED   = 2'd0;
	localparam logic [1:0] KIND_FULL    = 2'd1;
	localparam logic [1:0] KIND_EXPIRED = 2'd2;
	localparam logic [1:0] KIND_SUMMARY = 2'd3;

	// handles are four bits wide, so only the first sixteen slots can be named
	localparam int HANDLE_W    = 4;
	localparam int NUM_HANDLES = 16;

	// token handed from cell to cell during an add or a walk
	typedef struct packed {
		logic                active;
		logic                is_add;
		logic [63:0]         now;        // deadline for an add, current time for a walk
		logic [31:0]         payload;
		logic                notify;
		logic                found;
		logic [63:0]         best;
		logic [HANDLE_W-1:0] best_slot;
	} tok_t;

	// result offered by one cell
	typedef struct packed {
		logic                valid;
		logic [1:0]          kind;
		logic [HANDLE_W-1:0] slot;
		logic [31:0]         tag;
		logic                last;
	} emit_t;

	// shared control from the top level to every cell
	typedef struct packed {
		logic                go;
		logic                cancel;
		logic [HANDLE_W-1:0] handle;
	} ctl_t;

	// one result item
	typedef struct packed {
		logic [1:0]          kind;
		logic [HANDLE_W-1:0] slot;
		logic [31:0]         tag;
		logic [63:0]         earliest;
		logic                earliest_valid;
		logic [HANDLE_W-1:0] earliest_slot;
		logic                last;
	} res_t;

endpackage

FILE: rtl/tte_req_if.sv
interface tte_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [63:0] now;
	logic [30:0] timeout;
	logic [31:0] payload;
	logic        has_callback;
	logic [3:0]  handle;

	modport source (
		output valid, action, now, timeout, payload, has_callback, handle,
		input  ready
	);
	modport sink (
		input  valid, action, now, timeout, payload, has_callback, handle,
		output ready
	);
endinterface

FILE: rtl/tte_rsp_if.sv
interface tte_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [3:0]  slot;
	logic [31:0] tag;
	logic [63:0] earliest;
	logic        earliest_valid;
	logic [3:0]  earliest_slot;
	logic        last;

	modport source (
		output valid, kind, slot, tag, earliest, earliest_valid, earliest_slot, last,
		input  ready
	);
	modport sink (
		input  valid, kind, slot, tag, earliest, earliest_valid, earliest_slot, last,
		output ready
	);
endinterface

FILE: rtl/tte_cell.sv
module tte_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tte_pkg::ctl_t ctl,
	input  tte_pkg::tok_t tok_in,
	output tte_pkg::tok_t tok_out,
	output tte_pkg::emit_t emit
);
	import tte_pkg::*;

	localparam logic HANDLE_OK = (IDX < NUM_HANDLES);

	logic        valid_q;
	logic        canceled_q;
	logic [63:0] deadline_q;
	logic [31:0] tag_q;
	logic        notify_q;
	tok_t        tok_q;

	tok_t  tok_nxt;
	emit_t emit_c;
	logic  claim;
	logic  free;
	logic  hit;

	assign hit = HANDLE_OK && (ctl.handle == HANDLE_W'(IDX));

	// evaluate the token that sits at this cell
	always_comb begin
		tok_nxt = tok_in;
		emit_c  = '0;
		claim   = 1'b0;
		free    = 1'b0;
		if (tok_in.active) begin
			if (tok_in.is_add) begin
				if (!valid_q) begin
					claim          = 1'b1;
					tok_nxt.active = 1'b0;
					emit_c.valid   = 1'b1;
					emit_c.kind    = KIND_ADDED;
					emit_c.slot    = HANDLE_W'(IDX);
					emit_c.last    = 1'b1;
				end
			end else if (valid_q) begin
				if ((tok_in.now >= deadline_q) || canceled_q) begin
					free = 1'b1;
					if (notify_q && !canceled_q) begin
						emit_c.valid = 1'b1;
						emit_c.kind  = KIND_EXPIRED;
						emit_c.slot  = HANDLE_W'(IDX);
						emit_c.tag   = tag_q;
					end
				end else if (!tok_in.found || (deadline_q < tok_in.best)) begin
					tok_nxt.found     = 1'b1;
					tok_nxt.best      = deadline_q;
					tok_nxt.best_slot = HANDLE_W'(IDX);
				end
			end
		end
	end

	assign emit    = emit_c;
	assign tok_out = tok_q;

	// slot status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			canceled_q <= 1'b0;
		end else if (ctl.go && claim) begin
			valid_q    <= 1'b1;
			canceled_q <= 1'b0;
		end else if (ctl.go && free) begin
			valid_q    <= 1'b0;
			canceled_q <= 1'b0;
		end else if (ctl.cancel && hit && valid_q) begin
			canceled_q <= 1'b1;
		end
	end

	// slot data
	always_ff @(posedge clk) begin
		if (ctl.go && claim) begin
			deadline_q <= tok_in.now;
			tag_q      <= tok_in.payload;
			notify_q   <= tok_in.notify;
		end
	end

	// token handed to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (ctl.go) begin
			tok_q <= tok_nxt;
		end
	end

endmodule

FILE: rtl/timer_table_expiry.sv
// channel  modport  direction  carries
// req      sink     in         action, now, timeout, payload, has_callback, handle
// rsp      source   out        kind, slot, tag, earliest, earliest_valid, earliest_slot, last
//
// a cancel request only marks its slot canceled; an add or walk request runs a token down the
// row of SLOTS cells, one cell per cycle while the response register does not stall the row
// no new request is taken until the final result of an add or walk is registered
// the response register holds one result; while it is full and not taken, the
// whole cell row stalls
// arst_n clears every slot to free and empties the token row and the response
module timer_table_expiry #(
	parameter int SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	tte_req_if.sink   req,
	tte_rsp_if.source rsp
);
	import tte_pkg::*;

	tok_t  chain [SLOTS+1];
	emit_t emits [SLOTS];
	tok_t  start_q;
	ctl_t  ctl;
	emit_t emit_any;
	res_t  res;
	res_t  rsp_q;
	logic  res_v;
	logic  rsp_valid_q;
	logic  busy_q;
	logic  go;
	logic  accept;
	logic  start;
	logic [64:0] sum;
	logic [63:0] deadline;
	tok_t  tail;

	assign go        = !rsp_valid_q || rsp.ready;
	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign start     = accept && ((req.action == ACT_ADD) || (req.action == ACT_WALK));

	// saturating deadline
	assign sum      = {1'b0, req.now} + 65'(req.timeout);
	assign deadline = sum[64] ? '1 : sum[63:0];

	// token injection at the head of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (start) begin
			start_q.active    <= 1'b1;
			start_q.is_add    <= (req.action == ACT_ADD);
			start_q.now       <= (req.action == ACT_ADD) ? deadline : req.now;
			start_q.payload   <= req.payload;
			start_q.notify    <= req.has_callback;
			start_q.found     <= 1'b0;
			start_q.best      <= '0;
			start_q.best_slot <= '0;
		end else if (go) begin
			start_q.active <= 1'b0;
		end
	end

	assign ctl.go     = go;
	assign ctl.cancel = accept && (req.action == ACT_CANCEL);
	assign ctl.handle = req.handle;

	assign chain[0] = start_q;

	// row of slot cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		tte_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.tok_in (chain[i]),
			.tok_out(chain[i+1]),
			.emit   (emits[i])
		);
	end

	assign tail = chain[SLOTS];

	// at most one cell holds an active token, so the offers merge by or
	always_comb begin
		emit_any = '0;
		for (int i = 0; i < SLOTS; i++) begin
			emit_any = emit_any | emits[i];
		end
	end

	// pick the result of this cycle
	always_comb begin
		res   = '0;
		res_v = 1'b0;
		if (emit_any.valid) begin
			res_v     = 1'b1;
			res.kind  = emit_any.kind;
			res.slot  = emit_any.slot;
			res.tag   = emit_any.tag;
			res.last  = emit_any.last;
		end else if (tail.active) begin
			res_v    = 1'b1;
			res.last = 1'b1;
			if (tail.is_add) begin
				res.kind = KIND_FULL;
			end else begin
				res.kind           = KIND_SUMMARY;
				res.earliest       = tail.best;
				res.earliest_valid = tail.found;
				res.earliest_slot  = tail.best_slot;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go) begin
			rsp_valid_q <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_q <= res;
		end
	end

	// busy from an add or walk request until its final result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (go && res_v && res.last) begin
			busy_q <= 1'b0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.kind           = rsp_q.kind;
	assign rsp.slot           = rsp_q.slot;
	assign rsp.tag            = rsp_q.tag;
	assign rsp.earliest       = rsp_q.earliest;
	assign rsp.earliest_valid = rsp_q.earliest_valid;
	assign rsp.earliest_slot  = rsp_q.earliest_slot;
	assign rsp.last           = rsp_q.last;

endmodule
